@@ sv/cam_pkg.sv @@
// Package for the centered absolute moving average block: field widths,
// default sizes and the job record that passes from the front end to the divider.
// No dependencies.
package cam_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int MAG_W      = 16;
    localparam int ENERGY_W   = 16;
    localparam int HALF_W     = 6;
    localparam int WIN_W      = HALF_W + 1;
    localparam int SUM_W      = 23;
    localparam int FILL_W     = 7;
    localparam logic [FILL_W-1:0] FILL_CAP = 7'd127;

    localparam int MAX_HALF_WINDOW_DEF = 63;
    localparam int RING_DEPTH_DEF      = 128;
    localparam int QUEUE_DEPTH         = 4;

    // Effective half window and full window size, stable while items flow.
    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic [WIN_W-1:0]  win;
    } t_win;

    // One pending division: the window sum and the flags of its result.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             run_end;
        logic             buffer_end;
    } t_job;

endpackage

@@ sv/cam_if.sv @@
// Handshake channels of the block: the sample input and the energy output.
// Depends on cam_pkg.
interface cam_smp_if import cam_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source(output valid, output sample, output last_sample, input ready);
    modport sink(input valid, input sample, input last_sample, output ready);
endinterface

interface cam_nrg_if import cam_pkg::*;;
    logic                valid;
    logic                ready;
    logic [ENERGY_W-1:0] energy;
    logic                run_end;
    logic                buffer_end;

    modport source(output valid, output energy, output run_end, output buffer_end, input ready);
    modport sink(input valid, input energy, input run_end, input buffer_end, output ready);
endinterface

@@ sv/centered_abs_moving_average.sv @@
// Channel   Dir  Modport  Payload                          Beat when
// i_smp     in   sink     sample, last_sample              valid && ready
// o_nrg     out  source   energy, run_end, buffer_end      valid && ready
// i_cfg_*   in   -        half_window (6 bits)             i_cfg_we high
//
// The front end takes a new sample only when it has finished with the last one and
// any results that it owes or flushes; the 4-entry job queue lets it run ahead.
// Each result passes through the back end's serial divider, one quotient bit per
// step, plus pop and output load, which sets the sustained rate.
// Reset is synchronous; the ring memory needs no clearing pass since only entries
// written in the current buffer are read back.
// A stalled output holds its beat; the divider waits in its final state meanwhile.
// Top level; depends on cam_pkg, cam_if, cam_ram, cam_front, cam_fifo, cam_back.
module centered_abs_moving_average import cam_pkg::*; #(
    parameter int MAX_HALF_WINDOW = MAX_HALF_WINDOW_DEF,
    parameter int RING_DEPTH      = RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [HALF_W-1:0] i_cfg_data,
    cam_smp_if.sink           i_smp,
    cam_nrg_if.source         o_nrg
);
    localparam int RING_HALF = (RING_DEPTH - 1) / 2;
    localparam int HALF_CAP  = (MAX_HALF_WINDOW < RING_HALF) ? MAX_HALF_WINDOW : RING_HALF;
    localparam logic [HALF_W-1:0] HALF_CAP_V = HALF_W'(HALF_CAP);

    logic [HALF_W-1:0] r_half_window;
    logic [HALF_W-1:0] half_eff;
    t_win              win;
    t_job              push_job;
    t_job              pop_job;
    logic              push;
    logic              pop;
    logic              full;
    logic              empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_window <= '0;
        end else if (i_cfg_we) begin
            r_half_window <= i_cfg_data;
        end
    end

    assign half_eff = (r_half_window > HALF_CAP_V) ? HALF_CAP_V : r_half_window;
    assign win      = '{half: half_eff, win: {half_eff, 1'b1}};

    cam_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_win   (win),
        .i_smp   (i_smp),
        .o_job   (push_job),
        .o_push  (push),
        .i_full  (full)
    );

    cam_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (pop_job),
        .o_empty (empty)
    );

    cam_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_win   (win),
        .i_job   (pop_job),
        .i_empty (empty),
        .o_pop   (pop),
        .o_nrg   (o_nrg)
    );
endmodule

@@ sv/cam_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Reading the address being written returns the old contents. No dependencies.
module cam_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ sv/cam_front.sv @@
// Front end: takes samples, keeps the magnitude ring and the running window sum,
// and queues one division job per result. Depends on cam_pkg, cam_if and cam_ram.
module cam_front import cam_pkg::*; #(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_win  i_win,
    cam_smp_if.sink i_smp,
    output t_job  o_job,
    output logic  o_push,
    input  logic  i_full
);
    localparam int AW = $clog2(RING_DEPTH);
    localparam int XW = WIN_W + 1;
    localparam logic [XW-1:0] DEPTH_X = XW'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_SUB, S_PUSH, S_FRD, S_FSUB} t_state;
    typedef enum logic [1:0] {M_MAIN, M_FLUSH, M_SHORT} t_mode;

    t_state            r_state;
    t_mode             r_mode;
    logic [SUM_W-1:0]  r_sum;
    logic [AW-1:0]     r_wp;
    logic [FILL_W-1:0] r_fill;
    logic [AW-1:0]     r_base;
    logic [FILL_W-1:0] r_before;
    logic              r_last;
    logic [MAG_W-1:0]  r_mag;
    logic [HALF_W-1:0] r_k;

    logic              accept;
    logic [MAG_W-1:0]  mag;
    logic [AW-1:0]     ram_raddr;
    logic [MAG_W-1:0]  ram_rdata;
    logic [WIN_W-1:0]  flush_d;
    logic [SUM_W-1:0]  drop_main;
    logic [SUM_W-1:0]  drop_flush;
    logic              half_zero;
    logic              job_run_end;
    logic              job_buffer_end;
    logic              item_done;

    // Slot of the position that lies off places before base; off never exceeds the depth.
    function automatic logic [AW-1:0] slot_back(input logic [AW-1:0] base,
                                                input logic [WIN_W-1:0] off);
        logic [XW-1:0] b;
        logic [XW-1:0] o;
        logic [XW-1:0] s;
        b = {{(XW-AW){1'b0}}, base};
        o = {1'b0, off};
        if (o >= DEPTH_X) begin
            o = o - DEPTH_X;
        end
        if (b >= o) begin
            s = b - o;
        end else begin
            s = b + DEPTH_X - o;
        end
        return s[AW-1:0];
    endfunction

    assign accept      = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign mag = i_smp.sample[SAMPLE_W-1] ? MAG_W'(~i_smp.sample + 1'b1)
                                          : MAG_W'(i_smp.sample);

    assign flush_d   = i_win.win - {1'b0, r_k};
    assign ram_raddr = (r_state == S_FRD) ? slot_back(r_base, flush_d)
                                          : slot_back(r_wp, i_win.win);

    cam_ram #(.WIDTH(MAG_W), .DEPTH(RING_DEPTH)) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (mag),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Only positions taken in during this buffer are ever subtracted.
    assign drop_main  = (r_before >= FILL_W'(i_win.win))
                        ? {{(SUM_W-MAG_W){1'b0}}, ram_rdata} : '0;
    assign drop_flush = (r_before >= FILL_W'(flush_d))
                        ? {{(SUM_W-MAG_W){1'b0}}, ram_rdata} : '0;
    assign half_zero  = (i_win.half == '0);

    always_comb begin
        unique case (r_mode)
            M_MAIN: begin
                job_run_end    = !r_last || half_zero;
                job_buffer_end = r_last && half_zero;
                item_done      = !(r_last && !half_zero);
            end
            M_FLUSH: begin
                job_run_end    = (r_k == i_win.half);
                job_buffer_end = job_run_end;
                item_done      = job_run_end;
            end
            M_SHORT: begin
                job_run_end    = ({1'b0, r_k} == r_before);
                job_buffer_end = job_run_end;
                item_done      = job_run_end;
            end
            default: begin
                job_run_end    = 1'b0;
                job_buffer_end = 1'b0;
                item_done      = 1'b1;
            end
        endcase
    end

    assign o_push = (r_state == S_PUSH) && !i_full;
    assign o_job  = '{sum: r_sum, run_end: job_run_end, buffer_end: job_buffer_end};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= S_IDLE;
            r_mode  <= M_MAIN;
            r_sum   <= '0;
            r_wp    <= '0;
            r_fill  <= '0;
            r_k     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_base   <= r_wp;
                        r_before <= r_fill;
                        r_last   <= i_smp.last_sample;
                        r_mag    <= mag;
                        r_wp     <= (r_wp == LAST_SLOT) ? '0 : r_wp + 1'b1;
                        r_fill   <= (r_fill < FILL_CAP) ? r_fill + 1'b1 : FILL_CAP;
                        r_state  <= S_SUB;
                    end
                end
                S_SUB: begin
                    r_sum <= r_sum - drop_main + {{(SUM_W-MAG_W){1'b0}}, r_mag};
                    if (r_before >= {1'b0, i_win.half}) begin
                        r_mode  <= M_MAIN;
                        r_state <= S_PUSH;
                    end else if (r_last) begin
                        // Short buffer: every position sees the whole buffer.
                        r_mode  <= M_SHORT;
                        r_k     <= '0;
                        r_state <= S_PUSH;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_PUSH: begin
                    if (!i_full) begin
                        if (item_done) begin
                            if (r_last) begin
                                r_sum  <= '0;
                                r_wp   <= '0;
                                r_fill <= '0;
                            end
                            r_state <= S_IDLE;
                        end else begin
                            unique case (r_mode)
                                M_MAIN: begin
                                    r_mode  <= M_FLUSH;
                                    r_k     <= HALF_W'(1);
                                    r_state <= S_FRD;
                                end
                                M_FLUSH: begin
                                    r_k     <= r_k + 1'b1;
                                    r_state <= S_FRD;
                                end
                                M_SHORT: begin
                                    r_k     <= r_k + 1'b1;
                                end
                                default: begin
                                    r_state <= S_IDLE;
                                end
                            endcase
                        end
                    end
                end
                S_FRD: begin
                    r_state <= S_FSUB;
                end
                S_FSUB: begin
                    r_sum   <= r_sum - drop_flush;
                    r_state <= S_PUSH;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/cam_fifo.sv @@
// Short job queue between the front end and the divider.
// Depends on cam_pkg.
module cam_fifo import cam_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_clear,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

@@ sv/cam_back.sv @@
// Back end: bit-serial divider that turns a window sum into the mean, plus the
// output register. Depends on cam_pkg and cam_if.
module cam_back import cam_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_win  i_win,
    input  t_job  i_job,
    input  logic  i_empty,
    output logic  o_pop,
    cam_nrg_if.source o_nrg
);
    localparam int CNT_W = $clog2(ENERGY_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ENERGY_W - 1);

    typedef enum logic [1:0] {B_IDLE, B_RUN, B_HOLD} t_state;

    t_state              r_state;
    logic [WIN_W-1:0]    r_rem;
    logic [ENERGY_W-1:0] r_dvd;
    logic [CNT_W-1:0]    r_cnt;
    logic                r_run_end;
    logic                r_buffer_end;
    logic                r_out_valid;
    logic [ENERGY_W-1:0] r_energy;
    logic                r_out_run_end;
    logic                r_out_buffer_end;

    logic [WIN_W:0]      shifted;
    logic [WIN_W+1:0]    diff;
    logic                borrow;
    logic                out_load;

    // The quotient never reaches 2^16, so the top sum bits start out below the
    // divisor and only the low sixteen bits need a step each.
    assign shifted = {r_rem, r_dvd[ENERGY_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, i_win.win};
    assign borrow  = diff[WIN_W+1];

    // The output register takes a new beat when it is empty or being drained.
    assign out_load = (r_state == B_HOLD) && (!r_out_valid || o_nrg.ready);

    assign o_pop             = (r_state == B_IDLE) && !i_empty;
    assign o_nrg.valid       = r_out_valid;
    assign o_nrg.energy      = r_energy;
    assign o_nrg.run_end     = r_out_run_end;
    assign o_nrg.buffer_end  = r_out_buffer_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_nrg.valid && o_nrg.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        r_rem        <= i_job.sum[SUM_W-1:ENERGY_W];
                        r_dvd        <= i_job.sum[ENERGY_W-1:0];
                        r_run_end    <= i_job.run_end;
                        r_buffer_end <= i_job.buffer_end;
                        r_cnt        <= '0;
                        r_state      <= B_RUN;
                    end
                end
                B_RUN: begin
                    // Quotient bits shift in where the dividend bits leave.
                    r_rem   <= borrow ? shifted[WIN_W-1:0] : diff[WIN_W-1:0];
                    r_dvd   <= {r_dvd[ENERGY_W-2:0], !borrow};
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= B_HOLD;
                    end
                end
                B_HOLD: begin
                    if (out_load) begin
                        r_energy         <= r_dvd;
                        r_out_run_end    <= r_run_end;
                        r_out_buffer_end <= r_buffer_end;
                        r_state          <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end
endmodule

@@ sv/cam_chk.sv @@
// Port-level checker for the centered absolute moving average block, bound to
// the top level. Depends on cam_pkg.
module cam_chk import cam_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [ENERGY_W-1:0] i_energy,
    input logic                i_run_end,
    input logic                i_buffer_end
);
    localparam logic [ENERGY_W-1:0] ENERGY_MAX = ENERGY_W'(32768);

    logic r_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_in_valid && i_in_ready) begin
            r_seen <= 1'b1;
        end
    end

    // A result can only follow some sample beat since reset.
    a_no_result_before_input: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) i_out_valid |-> r_seen)
        else $error("result shown before any sample was taken");

    // The mean of 16-bit magnitudes cannot exceed full scale.
    a_energy_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n) i_out_valid |-> (i_energy <= ENERGY_MAX))
        else $error("energy above full scale");

    // The buffer's final position always closes the run of its input.
    a_buffer_end_closes_run: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_buffer_end) |-> i_run_end)
        else $error("buffer end without run end");

    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_energy) && $stable(i_run_end) && $stable(i_buffer_end)))
        else $error("stalled result changed");
endmodule

bind centered_abs_moving_average cam_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_smp.valid),
    .i_in_ready   (i_smp.ready),
    .i_out_valid  (o_nrg.valid),
    .i_out_ready  (o_nrg.ready),
    .i_energy     (o_nrg.energy),
    .i_run_end    (o_nrg.run_end),
    .i_buffer_end (o_nrg.buffer_end)
);

@@ verif/tb_top.sv @@
// Testbench for centered_abs_moving_average: a directed table, then random buffers over
// several half-window settings, each energy beat checked against a typed value or an in-bench predictor.
// Depends on cam_pkg, cam_if and the block's RTL.
module tb_top;
    import cam_pkg::*;

    localparam int RING        = 128;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int N_DIRECTED  = 25;
    localparam int N_PHASES    = 7;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                run_end;
        logic                buffer_end;
    } t_energy;

    typedef struct packed {
        logic              cfg;
        logic [HALF_W-1:0] half;
        logic [15:0]       sample;
        logic              lst;
        logic              typed;
        t_energy           want;
    } t_step_row;

    // Rows with typed = 1 carry a result that is obvious by hand; the rest go
    // through the predictor.
    localparam t_step_row DIRECTED [N_DIRECTED] = '{
        '{1'b0, 6'd0,  16'h7FFF, 1'b0, 1'b1, '{16'd32767, 1'b1, 1'b0}},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b1, '{16'h8000,  1'b1, 1'b0}},
        '{1'b0, 6'd0,  16'hFFFF, 1'b0, 1'b1, '{16'd1,     1'b1, 1'b0}},
        '{1'b0, 6'd0,  16'h0000, 1'b1, 1'b1, '{16'd0,     1'b1, 1'b1}},
        '{1'b1, 6'd63, 16'h8000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'h7FFF, 1'b1, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b1, 6'd1,  16'd300,  1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'hFDA8, 1'b0, 1'b1, '{16'd300,   1'b1, 1'b0}},
        '{1'b0, 6'd0,  16'd900,  1'b1, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd5,    1'b1, 1'b1, '{16'd1,     1'b1, 1'b1}},
        '{1'b1, 6'd2,  16'd1000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'hF830, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd3000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'h7FFF, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd7,    1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'hFFF9, 1'b1, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b1, 6'd3,  16'd100,  1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd200,  1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b1, 6'd3,  16'd400,  1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd50,   1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'd60,   1'b1, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b1, 6'd5,  16'h8000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'h8000, 1'b0, 1'b0, '{16'd0,     1'b0, 1'b0}},
        '{1'b0, 6'd0,  16'h8000, 1'b1, 1'b0, '{16'd0,     1'b0, 1'b0}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [HALF_W-1:0] i_cfg_data;

    cam_smp_if smp();
    cam_nrg_if nrg();

    centered_abs_moving_average DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_smp      (smp),
        .o_nrg      (nrg)
    );

    // Predictor state, mirroring the block's buffer.
    logic [MAG_W-1:0]  mag_ring [RING];
    logic [SUM_W-1:0]  win_sum;
    logic [FILL_W-1:0] wr_pos;
    logic [FILL_W-1:0] fill;
    logic [HALF_W-1:0] half_cfg;

    t_energy energy_q [$];
    int      mismatches = 0;
    int      beats_seen = 0;
    bit      tx_burst   = 1'b0;
    bit      rx_burst   = 1'b0;

    task automatic clear_buffer();
        for (int j = 0; j < RING; j++) mag_ring[j] = '0;
        win_sum = '0;
        wr_pos  = '0;
        fill    = '0;
    endtask

    task automatic log_energy(input int win, input bit re, input bit be, input bit keep);
        logic [SUM_W-1:0] q;
        q = win_sum / SUM_W'(win);
        if (keep) energy_q.push_back('{energy: q[ENERGY_W-1:0], run_end: re, buffer_end: be});
    endtask

    task automatic predict_energy(input logic [15:0] s, input logic lst, input bit keep);
        int               h, win, prior, k, d, c;
        logic [MAG_W-1:0] mag;
        logic [6:0]       base;
        h      = half_cfg;
        win    = 2 * h + 1;
        mag    = s[15] ? (~s + 16'd1) : s;
        prior  = fill;
        base   = wr_pos;
        if (prior >= win) win_sum = win_sum - mag_ring[7'(int'(base) - win)];
        win_sum        = win_sum + mag;
        mag_ring[base] = mag;
        wr_pos         = base + 7'd1;
        fill           = (prior < 127) ? FILL_W'(prior + 1) : FILL_CAP;
        if (prior >= h) begin
            log_energy(win, !lst || h == 0, lst && h == 0, keep);
            if (lst) begin
                // Flush: the window slides past the end, dropping its oldest entry.
                for (k = 1; k <= h; k++) begin
                    d = win - k;
                    if (prior >= d) win_sum = win_sum - mag_ring[7'(int'(base) - d)];
                    log_energy(win, k == h, k == h, keep);
                end
            end
        end else if (lst) begin
            // Short buffer: every window covers all of it.
            for (c = 0; c <= prior; c++) log_energy(win, c == prior, c == prior, keep);
        end
        if (lst) clear_buffer();
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        smp.valid <= 1'b0;
        while (energy_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);
    endtask

    task automatic write_half(input logic [HALF_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        half_cfg = value;
        clear_buffer();
    endtask

    task automatic push_sample(input logic [15:0] s, input logic lst, input bit keep);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        repeat (gap) begin
            smp.valid <= 1'b0;
            @(negedge i_clk);
        end
        smp.valid       <= 1'b1;
        smp.sample      <= s;
        smp.last_sample <= lst;
        do @(posedge i_clk); while (!smp.ready);
        predict_energy(s, lst, keep);
    endtask

    function automatic logic [15:0] draw_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'($urandom_range(0, 15) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : cycle_guard
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        t_energy got, want;
        if (i_rst_n && nrg.valid && nrg.ready) begin
            got = '{energy: nrg.energy, run_end: nrg.run_end, buffer_end: nrg.buffer_end};
            beats_seen++;
            if (energy_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("beat %0d: no energy expected, got %0d run_end %0b buffer_end %0b",
                             beats_seen, got.energy, got.run_end, got.buffer_end);
            end else begin
                want = energy_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: expected %0d run_end %0b buffer_end %0b, ",
                                  "got %0d run_end %0b buffer_end %0b"},
                                 beats_seen, want.energy, want.run_end, want.buffer_end,
                                 got.energy, got.run_end, got.buffer_end);
                end
            end
        end
    end

    // Output side: random ready gaps, and one long hold once results are flowing.
    initial begin : energy_sink
        int gap;
        bit held;
        held      = 1'b0;
        nrg.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 40) == 0) rx_burst = !rx_burst;
            if (!held && beats_seen >= 30) begin
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, 6);
            end
            repeat (gap) begin
                nrg.ready <= 1'b0;
                @(negedge i_clk);
            end
            nrg.ready <= 1'b1;
            do @(posedge i_clk); while (!nrg.valid);
        end
    end

    initial begin : stimulus
        int        i, p, n, k, len, h, budget, r;
        t_step_row row;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_data      = '0;
        smp.valid       = 1'b0;
        smp.sample      = '0;
        smp.last_sample = 1'b0;
        half_cfg        = '0;
        clear_buffer();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < N_DIRECTED; i++) begin
            row = DIRECTED[i];
            if (row.cfg) write_half(row.half);
            push_sample(row.sample, row.lst, !row.typed);
            if (row.typed) energy_q.push_back(row.want);
        end

        for (p = 0; p < N_PHASES; p++) begin
            case (p)
                0:       h = 63;
                1:       h = 0;
                2:       h = 1;
                3:       h = $urandom_range(2, 62);
                4:       h = 2;
                5:       h = $urandom_range(0, 63);
                default: h = 62;
            endcase
            write_half(HALF_W'(h));
            tx_burst = ($urandom_range(0, 3) == 0);
            budget   = (p == 0) ? 160 : 20;
            n        = 0;
            while (n < budget) begin
                r = $urandom_range(0, 9);
                if (p == 0 && n == 0) len = $urandom_range(130, 140);
                else if (r == 0)      len = $urandom_range(1, h + 1);
                else if (r == 1)      len = $urandom_range(h + 1, h + 3);
                else                  len = $urandom_range(1, 24);
                // A buffer cut off by the budget stays open until the next write.
                for (k = 0; k < len && n < budget; k++) begin
                    push_sample(draw_sample(), k == len - 1, 1'b1);
                    n++;
                    if (p == 0 && n == 70) wait_drained();
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
